[rtl/core/counting_semaphore_with_waiter_queue_macros.svh]
// ----------------------------------------------------------------------------
// Semaphore assertion macros
// Shared concurrent assertion forms for the semaphore checker.
// ----------------------------------------------------------------------------
`ifndef COUNTING_SEMAPHORE_WITH_WAITER_QUEUE_MACROS_SVH
`define COUNTING_SEMAPHORE_WITH_WAITER_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CSEM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define CSEM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/csem_pkg.sv]
// ----------------------------------------------------------------------------
// Semaphore package
// Command, status and wake codes, field widths, defaults and shared helpers.
// ----------------------------------------------------------------------------
package csem_pkg;

	// Field widths
	localparam int CMD_W    = 3;
	localparam int TID_W    = 6;
	localparam int TICKS_W  = 16;
	localparam int STATUS_W = 3;
	localparam int WK_W     = 2;
	localparam int COUNT_W  = 8;
	localparam int INIT_W   = 7;
	localparam int MOD_W    = TID_W + 9;

	// Parameter defaults
	localparam int QUEUE_DEPTH_DEF  = 16;
	localparam int THREAD_COUNT_DEF = 64;
	localparam int TIMER_BITS_DEF   = 16;

	// Commands
	localparam logic [CMD_W-1:0] CMD_WAIT       = 3'd0;
	localparam logic [CMD_W-1:0] CMD_TIMED_WAIT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_TRY_WAIT   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SIGNAL     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLOSE      = 3'd4;
	localparam logic [CMD_W-1:0] CMD_TICK       = 3'd5;
	localparam logic [CMD_W-1:0] CMD_READ_COUNT = 3'd6;
	localparam logic [CMD_W-1:0] CMD_UNUSED     = 3'd7;

	// Result status
	localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
	localparam logic [STATUS_W-1:0] ST_CLOSED      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_WOULD_BLOCK = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BLOCKED     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_QUEUE_FULL  = 3'd5;

	// Wake reasons
	localparam logic [WK_W-1:0] WK_SIGNAL  = 2'd0;
	localparam logic [WK_W-1:0] WK_CLOSED  = 2'd1;
	localparam logic [WK_W-1:0] WK_TIMEOUT = 2'd2;

	// Count limits
	localparam logic signed [COUNT_W-1:0] COUNT_MAX = 8'sd127;
	localparam logic signed [COUNT_W-1:0] COUNT_MIN = -8'sd128;

	// Per-cell control
	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctrl_t;

	// Reduce a thread id modulo a constant by restoring compare-subtract
	function automatic logic [TID_W-1:0] tid_mod(input logic [TID_W-1:0] value,
		input int unsigned modulus);
		logic [MOD_W-1:0] rem;
		logic [MOD_W-1:0] step;
		rem = MOD_W'(value);
		for (int b = TID_W - 1; b >= 0; b--) begin
			step = MOD_W'(modulus) << b;
			if (rem >= step) begin
				rem = rem - step;
			end
		end
		return rem[TID_W-1:0];
	endfunction

endpackage

[rtl/core/counting_semaphore_with_waiter_queue.sv]
// ----------------------------------------------------------------------------
// Counting semaphore with waiter queue
// Usage:
//   Command channel: start with command, thread_id, timeout_ticks; taken at an
//   edge where start is high and busy is low.
//   Results: one cycle each on status/woken_*/count_value, marked by done; last
//   flags the final result of a command. The receiver cannot stall results.
//   Config: initial_count is written when cfg_valid and cfg_ready are high;
//   cfg_ready is always high.
// Timing:
//   Wait, timed wait, try wait, read count and closed-state commands: result in
//   the cycle after the command; a new command may be taken in that cycle.
//   Signal: answers next cycle unless it pops; then busy while head entries are
//   dropped (up to QUEUE_DEPTH) until a live waiter turns up or the queue is empty, then the result.
//   Close and tick: the cell chain rotates once through S_SWEEP, emitting a
//   result for each released waiter, then the final result from S_FINAL.
// Reset:
//   Count, closed flag, queue and stored initial count clear; the count is loaded
//   from the stored initial count in the first cycle after reset, during which busy is high.
// ----------------------------------------------------------------------------
module counting_semaphore_with_waiter_queue import csem_pkg::*; #(
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
	parameter int THREAD_COUNT = THREAD_COUNT_DEF,
	parameter int TIMER_BITS   = TIMER_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [CMD_W-1:0]           command,
	input  logic [TID_W-1:0]           thread_id,
	input  logic [TICKS_W-1:0]         timeout_ticks,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [INIT_W-1:0]          initial_count,
	output logic                       done,
	output logic [STATUS_W-1:0]        status,
	output logic                       woken_valid,
	output logic [TID_W-1:0]           woken_thread,
	output logic [WK_W-1:0]            woken_status,
	output logic signed [COUNT_W-1:0]  count_value,
	output logic                       last
);

	localparam int UW = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_POP   = 2'd1;
	localparam logic [1:0] S_SWEEP = 2'd2;
	localparam logic [1:0] S_FINAL = 2'd3;

	// Control state
	logic [1:0]                 state_q, state_d;
	logic signed [COUNT_W-1:0]  count_q, count_d;
	logic                       closed_q, closed_d;
	logic [UW-1:0]              used_q, used_d;
	logic [UW-1:0]              idx_q, idx_d;
	logic                       sweep_close_q, sweep_close_d;
	logic                       load_q;
	logic [INIT_W-1:0]          init_count_q;

	// Result register
	logic                       done_q, done_d;
	logic [STATUS_W-1:0]        status_q, status_d;
	logic                       wv_q, wv_d;
	logic [TID_W-1:0]           wt_q, wt_d;
	logic [WK_W-1:0]            ws_q, ws_d;
	logic                       last_q, last_d;

	// Chain wiring
	logic                       accept;
	logic                       shift;
	logic                       enq;
	logic signed [COUNT_W-1:0]  cnt_dec;
	logic signed [COUNT_W-1:0]  cnt_inc;
	logic                       head_expire;
	logic [TID_W-1:0]           new_thread;
	logic                       new_timed;
	logic [TIMER_BITS-1:0]      new_rem;
	logic [TID_W-1:0]           tail_thread;
	logic                       tail_active;
	logic                       tail_timed;
	logic [TIMER_BITS-1:0]      tail_rem;
	cell_ctrl_t                 cell_ctrl  [QUEUE_DEPTH];
	logic [TID_W-1:0]           cell_thread[QUEUE_DEPTH];
	logic                       cell_active[QUEUE_DEPTH];
	logic                       cell_timed [QUEUE_DEPTH];
	logic [TIMER_BITS-1:0]      cell_rem   [QUEUE_DEPTH];

	assign busy      = load_q || (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// New waiter fields
	assign new_thread = tid_mod(thread_id, THREAD_COUNT);
	assign new_timed  = (command == CMD_TIMED_WAIT);
	assign new_rem    = TIMER_BITS'(timeout_ticks);

	// Saturating count steps
	assign cnt_dec = (count_q == COUNT_MIN) ? count_q : count_q - 8'sd1;
	assign cnt_inc = (count_q == COUNT_MAX) ? count_q : count_q + 8'sd1;

	// Head entry runs out on this tick when one or zero ticks remain
	assign head_expire = (cell_rem[0][TIMER_BITS-1:1] == '0);

	// Sequence commands over the cell chain
	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		closed_d      = closed_q;
		used_d        = used_q;
		idx_d         = idx_q;
		sweep_close_d = sweep_close_q;
		done_d        = 1'b0;
		status_d      = ST_OK;
		wv_d          = 1'b0;
		wt_d          = '0;
		ws_d          = WK_SIGNAL;
		last_d        = 1'b0;
		shift         = 1'b0;
		enq           = 1'b0;
		tail_thread   = cell_thread[0];
		tail_active   = 1'b0;
		tail_timed    = cell_timed[0];
		tail_rem      = cell_rem[0];

		case (state_q)
			S_IDLE: begin
				if (load_q) begin
					count_d = COUNT_W'(init_count_q);
				end else if (accept) begin
					done_d = 1'b1;
					last_d = 1'b1;
					if (command inside {CMD_READ_COUNT, CMD_UNUSED}) begin
						status_d = ST_OK;
					end else if (closed_q) begin
						status_d = ST_CLOSED;
					end else begin
						case (command)
							CMD_WAIT, CMD_TIMED_WAIT: begin
								if (count_q > 8'sd0) begin
									count_d = count_q - 8'sd1;
								end else if (used_q == UW'(QUEUE_DEPTH)) begin
									status_d = ST_QUEUE_FULL;
								end else begin
									count_d  = cnt_dec;
									enq      = 1'b1;
									used_d   = used_q + UW'(1);
									status_d = ST_BLOCKED;
								end
							end
							CMD_TRY_WAIT: begin
								if (count_q > 8'sd0) begin
									count_d = count_q - 8'sd1;
								end else begin
									status_d = ST_WOULD_BLOCK;
								end
							end
							CMD_SIGNAL: begin
								count_d = cnt_inc;
								if ((cnt_inc <= 8'sd0) && (used_q != '0)) begin
									done_d  = 1'b0;
									last_d  = 1'b0;
									state_d = S_POP;
								end
							end
							CMD_CLOSE: begin
								closed_d      = 1'b1;
								sweep_close_d = 1'b1;
								idx_d         = '0;
								done_d        = 1'b0;
								last_d        = 1'b0;
								state_d       = S_SWEEP;
							end
							CMD_TICK: begin
								sweep_close_d = 1'b0;
								idx_d         = '0;
								done_d        = 1'b0;
								last_d        = 1'b0;
								state_d       = S_SWEEP;
							end
							default: begin
								status_d = ST_OK;
							end
						endcase
					end
				end
			end
			S_POP: begin
				// Drop head entries until a live waiter turns up
				if (used_q == '0) begin
					done_d  = 1'b1;
					last_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					shift  = 1'b1;
					used_d = used_q - UW'(1);
					if (cell_active[0]) begin
						done_d  = 1'b1;
						last_d  = 1'b1;
						wv_d    = 1'b1;
						wt_d    = cell_thread[0];
						ws_d    = WK_SIGNAL;
						state_d = S_IDLE;
					end
				end
			end
			S_SWEEP: begin
				// Rotate the head to the tail, updating it on the way
				shift       = 1'b1;
				tail_active = cell_active[0];
				if ((idx_q < used_q) && cell_active[0]) begin
					if (sweep_close_q) begin
						tail_active = 1'b0;
						done_d      = 1'b1;
						wv_d        = 1'b1;
						wt_d        = cell_thread[0];
						ws_d        = WK_CLOSED;
					end else if (cell_timed[0]) begin
						if (head_expire) begin
							tail_active = 1'b0;
							tail_rem    = '0;
							done_d      = 1'b1;
							wv_d        = 1'b1;
							wt_d        = cell_thread[0];
							ws_d        = WK_TIMEOUT;
						end else begin
							tail_rem = cell_rem[0] - TIMER_BITS'(1);
						end
					end
				end
				if (idx_q == UW'(QUEUE_DEPTH - 1)) begin
					state_d = S_FINAL;
				end else begin
					idx_d = idx_q + UW'(1);
				end
			end
			S_FINAL: begin
				done_d  = 1'b1;
				last_d  = 1'b1;
				state_d = S_IDLE;
				if (sweep_close_q) begin
					used_d = '0;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Advance control and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			closed_q      <= 1'b0;
			used_q        <= '0;
			idx_q         <= '0;
			sweep_close_q <= 1'b0;
			load_q        <= 1'b1;
			done_q        <= 1'b0;
			status_q      <= ST_OK;
			wv_q          <= 1'b0;
			wt_q          <= '0;
			ws_q          <= WK_SIGNAL;
			last_q        <= 1'b0;
		end else begin
			state_q       <= state_d;
			count_q       <= count_d;
			closed_q      <= closed_d;
			used_q        <= used_d;
			idx_q         <= idx_d;
			sweep_close_q <= sweep_close_d;
			load_q        <= 1'b0;
			done_q        <= done_d;
			status_q      <= status_d;
			wv_q          <= wv_d;
			wt_q          <= wt_d;
			ws_q          <= ws_d;
			last_q        <= last_d;
		end
	end

	// Hold the configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			init_count_q <= initial_count;
		end
	end

	// Chain of waiter cells, head at index zero
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [TID_W-1:0]      nx_thread;
		logic                  nx_active;
		logic                  nx_timed;
		logic [TIMER_BITS-1:0] nx_rem;

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign nx_thread = tail_thread;
			assign nx_active = tail_active;
			assign nx_timed  = tail_timed;
			assign nx_rem    = tail_rem;
		end else begin : g_body
			assign nx_thread = cell_thread[i+1];
			assign nx_active = cell_active[i+1];
			assign nx_timed  = cell_timed[i+1];
			assign nx_rem    = cell_rem[i+1];
		end

		assign cell_ctrl[i] = '{shift: shift, load: enq && (used_q == UW'(i))};

		csem_cell #(
			.TIMER_BITS(TIMER_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (cell_ctrl[i]),
			.next_thread (nx_thread),
			.next_active (nx_active),
			.next_timed  (nx_timed),
			.next_rem    (nx_rem),
			.new_thread  (new_thread),
			.new_timed   (new_timed),
			.new_rem     (new_rem),
			.cur_thread  (cell_thread[i]),
			.cur_active  (cell_active[i]),
			.cur_timed   (cell_timed[i]),
			.cur_rem     (cell_rem[i])
		);
	end

	assign done         = done_q;
	assign status       = status_q;
	assign woken_valid  = wv_q;
	assign woken_thread = wt_q;
	assign woken_status = ws_q;
	assign count_value  = count_q;
	assign last         = last_q;

endmodule

[rtl/core/csem_cell.sv]
// ----------------------------------------------------------------------------
// Semaphore waiter cell
// One queue entry; loads a new waiter or takes its neighbor's entry on shift.
// ----------------------------------------------------------------------------
module csem_cell import csem_pkg::*; #(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cell_ctrl_t            ctrl,
	input  logic [TID_W-1:0]      next_thread,
	input  logic                  next_active,
	input  logic                  next_timed,
	input  logic [TIMER_BITS-1:0] next_rem,
	input  logic [TID_W-1:0]      new_thread,
	input  logic                  new_timed,
	input  logic [TIMER_BITS-1:0] new_rem,
	output logic [TID_W-1:0]      cur_thread,
	output logic                  cur_active,
	output logic                  cur_timed,
	output logic [TIMER_BITS-1:0] cur_rem
);

	logic [TID_W-1:0]      thread_q;
	logic                  active_q;
	logic                  timed_q;
	logic [TIMER_BITS-1:0] rem_q;

	// Flags: take neighbor on shift, set on load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			timed_q  <= 1'b0;
		end else if (ctrl.shift) begin
			active_q <= next_active;
			timed_q  <= next_timed;
		end else if (ctrl.load) begin
			active_q <= 1'b1;
			timed_q  <= new_timed;
		end
	end

	// Payload: same selection, no reset
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			thread_q <= next_thread;
			rem_q    <= next_rem;
		end else if (ctrl.load) begin
			thread_q <= new_thread;
			rem_q    <= new_rem;
		end
	end

	assign cur_thread = thread_q;
	assign cur_active = active_q;
	assign cur_timed  = timed_q;
	assign cur_rem    = rem_q;

endmodule

[rtl/core/csem_checker.sv]
// ----------------------------------------------------------------------------
// Semaphore port checker
// Watches the top-level ports for result sequencing and wake reporting.
// ----------------------------------------------------------------------------
`include "counting_semaphore_with_waiter_queue_macros.svh"

module csem_checker import csem_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic [CMD_W-1:0]          command,
	input logic                      done,
	input logic [STATUS_W-1:0]       status,
	input logic                      woken_valid,
	input logic                      last
);

	// Read count and the unused code answer in the next cycle with a single ok result
	`CSEM_ASSERT_NEXT(a_read_count_single, start && !busy && (command == CMD_READ_COUNT || command == CMD_UNUSED), done && last && (status == ST_OK), "read count did not answer next cycle")

	// A released thread is only reported on an ok result
	`CSEM_ASSERT_IMP(a_woken_on_result, woken_valid, done && (status == ST_OK), "wake reported outside an ok result")

	// Results still to come keep the block busy
	`CSEM_ASSERT_IMP(a_more_results_busy, done && !last, busy, "block idle before the final result")

	// An accepted transaction either answers at once or keeps the block busy
	`CSEM_ASSERT_NEXT(a_accept_progress, start && !busy, done || busy, "accepted transaction dropped")

endmodule

bind counting_semaphore_with_waiter_queue csem_checker u_csem_checker (.*);

[sim/counting_semaphore_with_waiter_queue_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting semaphore with waiter queue testbench
// Drives command transactions with random gaps, tracks the semaphore count and
// the waiter queue in a local copy, and compares every result field by field.
// ----------------------------------------------------------------------------
module counting_semaphore_with_waiter_queue_test;
	import csem_pkg::*;

	localparam int DEPTH       = QUEUE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PRINT_LIMIT = 100;

	// Command mixes for the random phases
	localparam int MIX_EVEN   = 0;
	localparam int MIX_SIGNAL = 1;
	localparam int MIX_WAIT   = 2;
	localparam int MIX_ANY    = 3;

	typedef struct {
		logic [STATUS_W-1:0]       status;
		logic                      woken_valid;
		logic [TID_W-1:0]          woken_thread;
		logic [WK_W-1:0]           woken_status;
		logic signed [COUNT_W-1:0] level;
		logic                      last;
	} sem_reply_t;

	// Mirror of the semaphore state plus the replies still owed
	class semaphore_tracker;
		int                 mismatches;
		int                 level;
		logic               closed;
		logic [INIT_W-1:0]  init_reg;
		logic [TID_W-1:0]   slot_thread [DEPTH];
		logic               slot_active [DEPTH];
		logic               slot_timed [DEPTH];
		logic [TICKS_W-1:0] slot_left [DEPTH];
		int                 head;
		int                 used;
		sem_reply_t         owed_replies[$];

		function new();
			mismatches = 0;
			level = 0;
			closed = 1'b0;
			init_reg = '0;
			head = 0;
			used = 0;
			for (int i = 0; i < DEPTH; i++) begin
				slot_thread[i] = '0;
				slot_active[i] = 1'b0;
				slot_timed[i] = 1'b0;
				slot_left[i] = '0;
			end
		endfunction

		// Register only; the live count is untouched
		function void set_initial_count(logic [INIT_W-1:0] value);
			init_reg = value;
		endfunction

		function sem_reply_t reply(logic [STATUS_W-1:0] st, logic wv,
			logic [TID_W-1:0] who, logic [WK_W-1:0] why);
			sem_reply_t r;
			r.status = st;
			r.woken_valid = wv;
			r.woken_thread = wv ? who : '0;
			r.woken_status = wv ? why : '0;
			r.level = '0;
			r.last = 1'b0;
			return r;
		endfunction

		// Take one unit or queue the caller
		function logic [STATUS_W-1:0] enqueue_waiter(logic [TID_W-1:0] tid, logic timed,
			logic [TICKS_W-1:0] ticks);
			int s;
			if (level > 0) begin
				level--;
				return ST_OK;
			end
			if (used >= DEPTH)
				return ST_QUEUE_FULL;
			if (level > -128)
				level--;
			s = (head + used) % DEPTH;
			slot_thread[s] = tid;
			slot_active[s] = 1'b1;
			slot_timed[s] = timed;
			slot_left[s] = ticks;
			used++;
			return ST_BLOCKED;
		endfunction

		// Apply an accepted command and queue up the replies it causes
		function void take_command(logic [CMD_W-1:0] cmd, logic [TID_W-1:0] tid,
			logic [TICKS_W-1:0] ticks);
			sem_reply_t batch[$];
			sem_reply_t r;
			logic found;
			logic [TID_W-1:0] who;
			int s;
			found = 1'b0;
			who = '0;
			if (cmd == CMD_READ_COUNT || cmd == CMD_UNUSED) begin
				batch.push_back(reply(ST_OK, 1'b0, '0, '0));
			end else if (closed) begin
				batch.push_back(reply(ST_CLOSED, 1'b0, '0, '0));
			end else begin
				case (cmd)
					CMD_WAIT, CMD_TIMED_WAIT: begin
						batch.push_back(reply(enqueue_waiter(tid, cmd == CMD_TIMED_WAIT, ticks),
							1'b0, '0, '0));
					end
					CMD_TRY_WAIT: begin
						if (level > 0) begin
							level--;
							batch.push_back(reply(ST_OK, 1'b0, '0, '0));
						end else begin
							batch.push_back(reply(ST_WOULD_BLOCK, 1'b0, '0, '0));
						end
					end
					CMD_SIGNAL: begin
						if (level < 127)
							level++;
						// Pop the head, skipping timed-out entries, until a live waiter
						if (level <= 0) begin
							while (used > 0 && !found) begin
								if (slot_active[head]) begin
									found = 1'b1;
									who = slot_thread[head];
									slot_active[head] = 1'b0;
								end
								head = (head + 1) % DEPTH;
								used--;
							end
						end
						batch.push_back(reply(ST_OK, found, who, WK_SIGNAL));
					end
					CMD_CLOSE: begin
						closed = 1'b1;
						for (int i = 0; i < used; i++) begin
							s = (head + i) % DEPTH;
							if (slot_active[s]) begin
								slot_active[s] = 1'b0;
								batch.push_back(reply(ST_OK, 1'b1, slot_thread[s], WK_CLOSED));
							end
						end
						used = 0;
						batch.push_back(reply(ST_OK, 1'b0, '0, '0));
					end
					default: begin
						// Tick: count down timed waiters, release the expired ones
						for (int i = 0; i < used; i++) begin
							s = (head + i) % DEPTH;
							if (slot_active[s] && slot_timed[s]) begin
								if (slot_left[s] <= 1) begin
									slot_left[s] = '0;
									slot_active[s] = 1'b0;
									batch.push_back(reply(ST_OK, 1'b1, slot_thread[s], WK_TIMEOUT));
								end else begin
									slot_left[s]--;
								end
							end
						end
						batch.push_back(reply(ST_OK, 1'b0, '0, '0));
					end
				endcase
			end
			// Every reply carries the count after the whole command
			for (int k = 0; k < batch.size(); k++) begin
				r = batch[k];
				r.level = COUNT_W'(level);
				r.last = (k == batch.size() - 1);
				owed_replies.push_back(r);
			end
		endfunction

		function int outstanding();
			return owed_replies.size();
		endfunction

		task flag_mismatch(string what);
			if (mismatches < PRINT_LIMIT)
				$display("[%0t] mismatch: %s", $realtime, what);
			mismatches++;
		endtask

		// Compare one observed result against the oldest owed reply
		task match_result(sem_reply_t got);
			sem_reply_t want;
			if (owed_replies.size() == 0) begin
				flag_mismatch($sformatf("unexpected result st=%0d wv=%0d wt=%0d ws=%0d cnt=%0d last=%0d",
					got.status, got.woken_valid, got.woken_thread, got.woken_status,
					got.level, got.last));
			end else begin
				want = owed_replies.pop_front();
				if (got.status !== want.status || got.woken_valid !== want.woken_valid ||
					got.woken_thread !== want.woken_thread ||
					got.woken_status !== want.woken_status ||
					got.level !== want.level || got.last !== want.last) begin
					flag_mismatch($sformatf(
						"got st=%0d wv=%0d wt=%0d ws=%0d cnt=%0d last=%0d, want %0d %0d %0d %0d %0d %0d",
						got.status, got.woken_valid, got.woken_thread, got.woken_status,
						got.level, got.last, want.status, want.woken_valid, want.woken_thread,
						want.woken_status, want.level, want.last));
				end
			end
		endtask
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic [CMD_W-1:0]          command;
	logic [TID_W-1:0]          thread_id;
	logic [TICKS_W-1:0]        timeout_ticks;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [INIT_W-1:0]         initial_count;
	logic                      done;
	logic [STATUS_W-1:0]       status;
	logic                      woken_valid;
	logic [TID_W-1:0]          woken_thread;
	logic [WK_W-1:0]           woken_status;
	logic signed [COUNT_W-1:0] count_value;
	logic                      last;

	semaphore_tracker tracker;
	logic             idle_on;
	int               cycle_count;

	counting_semaphore_with_waiter_queue i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.thread_id     (thread_id),
		.timeout_ticks (timeout_ticks),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.initial_count (initial_count),
		.done          (done),
		.status        (status),
		.woken_valid   (woken_valid),
		.woken_thread  (woken_thread),
		.woken_status  (woken_status),
		.count_value   (count_value),
		.last          (last)
	);

	// 12 ns clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Sample results on the rising edge
	always @(posedge clk) begin
		sem_reply_t got;
		if (arst_n && done) begin
			got.status = status;
			got.woken_valid = woken_valid;
			got.woken_thread = woken_thread;
			got.woken_status = woken_status;
			got.level = count_value;
			got.last = last;
			tracker.match_result(got);
		end
	end

	// Abort a hung run
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// Mostly short gaps, a few long ones, none while idling is off
	function int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Drive one command transaction and hold it until accepted
	task send_command(logic [CMD_W-1:0] cmd, logic [TID_W-1:0] tid, logic [TICKS_W-1:0] ticks);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		thread_id <= tid;
		timeout_ticks <= ticks;
		@(posedge clk);
		while (busy) @(posedge clk);
		tracker.take_command(cmd, tid, ticks);
	endtask

	function logic [TICKS_W-1:0] pick_ticks();
		case ($urandom_range(0, 7))
			0: return TICKS_W'($urandom_range(0, 65535));
			1: return '1;
			default: return TICKS_W'($urandom_range(0, 4));
		endcase
	endfunction

	function logic [CMD_W-1:0] pick_command(int mix);
		int r;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_SIGNAL: begin
				if (r < 10) return CMD_WAIT;
				if (r < 20) return CMD_TIMED_WAIT;
				if (r < 25) return CMD_TRY_WAIT;
				if (r < 80) return CMD_SIGNAL;
				if (r < 92) return CMD_TICK;
				return CMD_READ_COUNT;
			end
			MIX_WAIT: begin
				if (r < 30) return CMD_WAIT;
				if (r < 55) return CMD_TIMED_WAIT;
				if (r < 65) return CMD_TRY_WAIT;
				if (r < 78) return CMD_SIGNAL;
				if (r < 95) return CMD_TICK;
				return CMD_READ_COUNT;
			end
			MIX_ANY: begin
				return CMD_W'($urandom_range(0, 7));
			end
			default: begin
				if (r < 18) return CMD_WAIT;
				if (r < 36) return CMD_TIMED_WAIT;
				if (r < 46) return CMD_TRY_WAIT;
				if (r < 72) return CMD_SIGNAL;
				if (r < 90) return CMD_TICK;
				if (r < 96) return CMD_READ_COUNT;
				return CMD_UNUSED;
			end
		endcase
	endfunction

	task run_random(int mix, int items);
		for (int i = 0; i < items; i++)
			send_command(pick_command(mix), TID_W'($urandom_range(0, 63)), pick_ticks());
	endtask

	// Drop start and wait until every owed reply has come and the block is idle
	task drain();
		@(negedge clk);
		start <= 1'b0;
		while (tracker.outstanding() != 0) @(posedge clk);
		while (busy) @(posedge clk);
		repeat (DEPTH + 4) @(posedge clk);
	endtask

	// Write the initial count register through its own channel
	task write_initial_count(logic [INIT_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		initial_count <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tracker.set_initial_count(value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		tracker = new();
		idle_on = 1'b1;
		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_READ_COUNT;
		thread_id = '0;
		timeout_ticks = '0;
		cfg_valid = 1'b0;
		initial_count = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// Hold off until the count has been loaded
		@(posedge clk);
		while (busy) @(posedge clk);
		write_initial_count('0);

		// Directed: unused code, would-block, timeouts skipped by signal, full queue
		send_command(CMD_UNUSED, '0, '0);
		send_command(CMD_TRY_WAIT, '0, '0);
		send_command(CMD_SIGNAL, '0, '0);
		send_command(CMD_TRY_WAIT, '1, '1);
		send_command(CMD_TIMED_WAIT, '1, '0);
		send_command(CMD_TIMED_WAIT, '0, '1);
		send_command(CMD_TICK, '0, '0);
		send_command(CMD_SIGNAL, '0, '0);
		for (int i = 0; i < DEPTH; i++)
			send_command((i % 2) ? CMD_TIMED_WAIT : CMD_WAIT, TID_W'(i * 4 + 3),
				(i % 4 == 1) ? TICKS_W'(1) : TICKS_W'(2));
		send_command(CMD_WAIT, 6'h2a, '0);
		send_command(CMD_TICK, '0, '0);
		drain();

		write_initial_count('1);
		run_random(MIX_EVEN, 45);
		drain();

		// Back to back, no idling
		write_initial_count(INIT_W'($urandom_range(1, 126)));
		idle_on = 1'b0;
		run_random(MIX_SIGNAL, 35);
		drain();

		idle_on = 1'b1;
		write_initial_count('0);
		run_random(MIX_WAIT, 40);
		drain();

		// Close with a loaded queue, then everything after it
		write_initial_count('1);
		send_command(CMD_CLOSE, '0, '0);
		send_command(CMD_CLOSE, '0, '0);
		run_random(MIX_ANY, 14);
		drain();

		if (tracker.mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[counting_semaphore_with_waiter_queue.f]
+incdir+rtl/core
rtl/core/csem_pkg.sv
rtl/core/csem_cell.sv
rtl/core/counting_semaphore_with_waiter_queue.sv
rtl/core/csem_checker.sv
sim/counting_semaphore_with_waiter_queue_test.sv
